### rtl/core/ebc_pkg.sv
// Shared types, constants and the addressing-mode decode function for the stepped 6502 core.
`timescale 1ns / 1ps
`default_nettype none
package ebc_pkg;

  typedef enum logic [3:0] {
    SQ_RST0 = 4'd0, SQ_VEC1 = 4'd1, SQ_VEC2 = 4'd2, SQ_OP = 4'd3,
    SQ_ZP = 4'd4, SQ_ABS1 = 4'd5, SQ_ABS2 = 4'd6, SQ_PTR = 4'd7,
    SQ_PLO = 4'd8, SQ_PHI = 4'd9, SQ_EXEC = 4'd10, SQ_DONE = 4'd11,
    SQ_INT1 = 4'd12, SQ_INT2 = 4'd13, SQ_INT3 = 4'd14, SQ_JSRH = 4'd15
  } seq_e;

  typedef enum logic [3:0] {
    M_BAD, M_IMP, M_STK, M_IMM, M_REL, M_ZP, M_ZPX, M_ZPY,
    M_ABS, M_ABSX, M_ABSY, M_INDX, M_INDY
  } amode_e;

  localparam logic [7:0] FL_N = 8'h80;
  localparam logic [7:0] FL_V = 8'h40;
  localparam logic [7:0] FL_U = 8'h20;
  localparam logic [7:0] FL_B = 8'h10;
  localparam logic [7:0] FL_D = 8'h08;
  localparam logic [7:0] FL_I = 8'h04;
  localparam logic [7:0] FL_Z = 8'h02;
  localparam logic [7:0] FL_C = 8'h01;

  localparam logic [15:0] VEC_NMI = 16'hfffa;
  localparam logic [15:0] VEC_RST = 16'hfffc;
  localparam logic [15:0] VEC_IRQ = 16'hfffe;

  localparam logic [7:0] OP_BRK = 8'h00;
  localparam logic [7:0] OP_PHP = 8'h08;
  localparam logic [7:0] OP_JSR = 8'h20;
  localparam logic [7:0] OP_PLP = 8'h28;
  localparam logic [7:0] OP_RTI = 8'h40;
  localparam logic [7:0] OP_PHA = 8'h48;
  localparam logic [7:0] OP_JMP = 8'h4c;
  localparam logic [7:0] OP_RTS = 8'h60;
  localparam logic [7:0] OP_PLA = 8'h68;
  localparam logic [7:0] OP_JMPI = 8'h6c;

  typedef struct packed {
    logic [15:0] bus_address;
    logic        bus_write;
    logic [7:0]  write_data;
    logic        opcode_fetch;
    logic        halted;
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  sp_out;
    logic [7:0]  status_out;
    logic [15:0] pc_out;
  } result_t;

  function automatic amode_e mode_of(input logic [7:0] op);
    logic [1:0] cc;
    logic [2:0] bbb;
    logic [2:0] aaa;
    amode_e m;
    cc = op[1:0];
    bbb = op[4:2];
    aaa = op[7:5];
    m = M_BAD;
    case (cc)
      2'd1: begin
        case (bbb)
          3'd0: m = M_INDX;
          3'd1: m = M_ZP;
          3'd2: m = (op == 8'h89) ? M_BAD : M_IMM;
          3'd3: m = M_ABS;
          3'd4: m = M_INDY;
          3'd5: m = M_ZPX;
          3'd6: m = M_ABSY;
          default: m = M_ABSX;
        endcase
      end
      2'd2: begin
        case (bbb)
          3'd0: m = (op == 8'ha2) ? M_IMM : M_BAD;
          3'd1: m = M_ZP;
          3'd2: m = M_IMP;
          3'd3: m = M_ABS;
          3'd5: m = (aaa == 3'd4 || aaa == 3'd5) ? M_ZPY : M_ZPX;
          3'd6: m = (op == 8'h9a || op == 8'hba) ? M_IMP : M_BAD;
          3'd7: m = (aaa == 3'd4) ? M_BAD : ((aaa == 3'd5) ? M_ABSY : M_ABSX);
          default: m = M_BAD;
        endcase
      end
      2'd0: begin
        case (bbb)
          3'd0: m = (aaa == 3'd1) ? M_ABS : ((aaa < 3'd4) ? M_STK :
                    ((aaa == 3'd4) ? M_BAD : M_IMM));
          3'd1: m = (aaa == 3'd0 || aaa == 3'd2 || aaa == 3'd3) ? M_BAD : M_ZP;
          3'd2: m = M_IMP;
          3'd3: m = (aaa == 3'd0) ? M_BAD : M_ABS;
          3'd4: m = M_REL;
          3'd5: m = (aaa == 3'd4 || aaa == 3'd5) ? M_ZPX : M_BAD;
          3'd6: m = M_IMP;
          default: m = (aaa == 3'd5) ? M_ABSX : M_BAD;
        endcase
      end
      default: m = M_BAD;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

### rtl/core/ebc_if.sv
// Valid/ready channel interfaces for the core's command and result streams.
`timescale 1ns / 1ps
`default_nettype none
interface ebc_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] read_data;
  logic       nmi_request;
  logic       irq_level;
  modport source (output valid, cmd, read_data, nmi_request, irq_level, input ready);
  modport sink (input valid, cmd, read_data, nmi_request, irq_level, output ready);
endinterface

interface ebc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] bus_address;
  logic        bus_write;
  logic [7:0]  write_data;
  logic        opcode_fetch;
  logic        halted;
  logic [7:0]  acc_out;
  logic [7:0]  x_out;
  logic [7:0]  y_out;
  logic [7:0]  sp_out;
  logic [7:0]  status_out;
  logic [15:0] pc_out;
  modport source (output valid, bus_address, bus_write, write_data, opcode_fetch, halted,
                  acc_out, x_out, y_out, sp_out, status_out, pc_out, input ready);
  modport sink (input valid, bus_address, bus_write, write_data, opcode_fetch, halted,
                acc_out, x_out, y_out, sp_out, status_out, pc_out, output ready);
endinterface
`default_nettype wire

### rtl/core/ebc_alu.sv
// ALU: logic, add/subtract, compare, bit test, loads, shifts/rotates and increments/decrements.
`timescale 1ns / 1ps
`default_nettype none
module ebc_alu (
  input  wire logic [7:0] op_i,
  input  wire logic [7:0] val_i,
  input  wire logic [7:0] acc_i,
  input  wire logic [7:0] x_i,
  input  wire logic [7:0] y_i,
  input  wire logic [7:0] p_i,
  input  wire logic       shift_i,
  output logic      [7:0] res_o,
  output logic      [7:0] acc_o,
  output logic      [7:0] x_o,
  output logic      [7:0] y_o,
  output logic      [7:0] p_o
);
  logic [8:0] sum;
  logic [7:0] addend;
  logic [7:0] cmp_reg;
  logic [8:0] cmp_diff;
  logic [7:0] nz;
  logic       nz_en;
  logic       cin;

  always_comb begin
    cin = p_i[0];
    addend = (op_i[7:5] == 3'd7) ? ~val_i : val_i;
    sum = {1'b0, acc_i} + {1'b0, addend} + {8'd0, cin};
    cmp_reg = (op_i[1:0] == 2'd1) ? acc_i : ((op_i[7:5] == 3'd6) ? y_i : x_i);
    cmp_diff = {1'b0, cmp_reg} - {1'b0, val_i};
    acc_o = acc_i;
    x_o = x_i;
    y_o = y_i;
    p_o = p_i;
    res_o = val_i;
    nz = 8'd0;
    nz_en = 1'b0;
    if (shift_i) begin
      case (op_i[7:5])
        3'd0: begin res_o = {val_i[6:0], 1'b0}; p_o[0] = val_i[7]; end
        3'd1: begin res_o = {val_i[6:0], cin}; p_o[0] = val_i[7]; end
        3'd2: begin res_o = {1'b0, val_i[7:1]}; p_o[0] = val_i[0]; end
        3'd3: begin res_o = {cin, val_i[7:1]}; p_o[0] = val_i[0]; end
        3'd6: res_o = val_i - 8'd1;
        default: res_o = val_i + 8'd1;
      endcase
      nz = res_o;
      nz_en = 1'b1;
    end else if (op_i[1:0] == 2'd1) begin
      nz_en = 1'b1;
      case (op_i[7:5])
        3'd0: acc_o = acc_i | val_i;
        3'd1: acc_o = acc_i & val_i;
        3'd2: acc_o = acc_i ^ val_i;
        3'd3, 3'd7: begin
          acc_o = sum[7:0];
          p_o[0] = sum[8];
          p_o[6] = ~(acc_i[7] ^ addend[7]) & (acc_i[7] ^ sum[7]);
        end
        3'd5: acc_o = val_i;
        3'd6: p_o[0] = ~cmp_diff[8];
        default: nz_en = 1'b0;
      endcase
      nz = (op_i[7:5] == 3'd6) ? cmp_diff[7:0] : acc_o;
    end else if (op_i[1:0] == 2'd2) begin
      x_o = val_i;
      nz = val_i;
      nz_en = 1'b1;
    end else begin
      nz_en = 1'b1;
      case (op_i[7:5])
        3'd1: begin
          nz_en = 1'b0;
          p_o[1] = (acc_i & val_i) == 8'd0;
          p_o[7] = val_i[7];
          p_o[6] = val_i[6];
        end
        3'd5: begin y_o = val_i; nz = val_i; end
        default: begin p_o[0] = ~cmp_diff[8]; nz = cmp_diff[7:0]; end
      endcase
    end
    if (nz_en) begin
      p_o[7] = nz[7];
      p_o[1] = nz == 8'd0;
    end
  end
endmodule
`default_nettype wire

### rtl/core/ebc_seq.sv
// Instruction sequencer: state registers and next-access logic, one step per transfer.
`timescale 1ns / 1ps
`default_nettype none
module ebc_seq (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic             cmd_i,
  input  wire logic [7:0]       d_i,
  input  wire logic             nmi_i,
  input  wire logic             irq_i,
  output ebc_pkg::result_t      res_o
);
  ebc_pkg::seq_e seq_q, seq_d;
  logic [7:0]  a_q, a_d, x_q, x_d, y_q, y_d, s_q, s_d, p_q, p_d, op_q, op_d, dl_q, dl_d;
  logic [15:0] pc_q, pc_d, al_q, al_d;
  logic        nmi_q, nmi_d, halt_q, halt_d;

  logic [15:0] ba;
  logic        bw, bf;
  logic [7:0]  bd;

  // alu hookup
  logic [7:0] alu_op, alu_val, alu_res, alu_a, alu_x, alu_y, alu_p;
  logic       alu_shift;
  ebc_alu u_alu (
    .op_i(alu_op), .val_i(alu_val), .acc_i(a_q), .x_i(x_q), .y_i(y_q), .p_i(p_q),
    .shift_i(alu_shift), .res_o(alu_res), .acc_o(alu_a), .x_o(alu_x), .y_o(alu_y),
    .p_o(alu_p)
  );

  ebc_pkg::amode_e mode_cur, mode_new;
  logic [7:0] idx_cur;
  logic [15:0] absa, ptra;
  logic [2:0] aaa;
  logic       br_set;

  always_comb begin
    mode_cur = ebc_pkg::mode_of(op_q);
    mode_new = ebc_pkg::mode_of(d_i);
    idx_cur = (mode_cur == ebc_pkg::M_ZPX || mode_cur == ebc_pkg::M_ABSX) ? x_q :
              ((mode_cur == ebc_pkg::M_ZPY || mode_cur == ebc_pkg::M_ABSY) ? y_q : 8'd0);
    absa = {d_i, dl_q} + {8'd0, idx_cur};
    ptra = {d_i, dl_q};
    aaa = op_q[7:5];
    case (aaa[2:1])
      2'd0: br_set = p_q[7];
      2'd1: br_set = p_q[6];
      2'd2: br_set = p_q[0];
      default: br_set = p_q[1];
    endcase
  end

  always_comb begin
    logic [7:0] pcur;
    logic [15:0] ea;
    logic do_bound, do_eff;
    seq_d = seq_q; a_d = a_q; x_d = x_q; y_d = y_q; s_d = s_q; p_d = p_q;
    pc_d = pc_q; al_d = al_q; op_d = op_q; dl_d = dl_q; nmi_d = nmi_q; halt_d = halt_q;
    ba = 16'd0; bw = 1'b0; bd = 8'd0; bf = 1'b0;
    alu_op = op_q; alu_val = d_i; alu_shift = 1'b0;
    do_bound = 1'b0; do_eff = 1'b0; ea = 16'd0; pcur = 8'd0;
    if (cmd_i) begin
      p_d = (p_q | 8'h34) & ~ebc_pkg::FL_D;
      s_d = 8'hff; halt_d = 1'b0; nmi_d = 1'b0; op_d = 8'd0;
      seq_d = ebc_pkg::SQ_RST0;
    end else if (!halt_q && nmi_i) begin
      nmi_d = 1'b1;
    end
    if (halt_d) begin
      ba = pc_q;
    end else begin
      case (seq_d)
        ebc_pkg::SQ_RST0: begin
          op_d = 8'd0; al_d = ebc_pkg::VEC_RST; ba = ebc_pkg::VEC_RST;
          seq_d = ebc_pkg::SQ_VEC1;
        end
        ebc_pkg::SQ_VEC1: begin
          dl_d = d_i;
          if (op_q == ebc_pkg::OP_RTS || op_q == ebc_pkg::OP_RTI) begin
            s_d = s_d + 8'd1; ba = {8'h01, s_d};
          end else begin
            ba = al_q + 16'd1;
          end
          seq_d = ebc_pkg::SQ_VEC2;
        end
        ebc_pkg::SQ_VEC2: begin
          pc_d = {d_i, dl_q} + ((op_q == ebc_pkg::OP_RTS) ? 16'd1 : 16'd0);
          do_bound = 1'b1;
        end
        ebc_pkg::SQ_OP: begin
          op_d = d_i;
          pc_d = pc_q + 16'd1;
          if (d_i == ebc_pkg::OP_BRK) begin
            pc_d = pc_q + 16'd2;
            al_d = ebc_pkg::VEC_IRQ; dl_d = p_q | ebc_pkg::FL_U | ebc_pkg::FL_B;
            bw = 1'b1; ba = {8'h01, s_q}; bd = pc_d[15:8]; s_d = s_q - 8'd1;
            seq_d = ebc_pkg::SQ_INT1;
          end else if (d_i == ebc_pkg::OP_JSR) begin
            ba = pc_d; pc_d = pc_d + 16'd1; seq_d = ebc_pkg::SQ_ABS1;
          end else if (d_i == ebc_pkg::OP_RTS) begin
            s_d = s_q + 8'd1; ba = {8'h01, s_d}; seq_d = ebc_pkg::SQ_VEC1;
          end else if (d_i == ebc_pkg::OP_RTI || d_i == ebc_pkg::OP_PLP ||
                       d_i == ebc_pkg::OP_PLA) begin
            s_d = s_q + 8'd1; ba = {8'h01, s_d}; seq_d = ebc_pkg::SQ_EXEC;
          end else if (d_i == ebc_pkg::OP_PHP || d_i == ebc_pkg::OP_PHA) begin
            bw = 1'b1; ba = {8'h01, s_q}; s_d = s_q - 8'd1;
            bd = (d_i == ebc_pkg::OP_PHP) ? (p_q | ebc_pkg::FL_U | ebc_pkg::FL_B) : a_q;
            seq_d = ebc_pkg::SQ_DONE;
          end else begin
            case (mode_new)
              ebc_pkg::M_IMP: begin
                alu_op = d_i; alu_val = a_q;
                case (d_i)
                  8'h0a, 8'h2a, 8'h4a, 8'h6a: begin
                    alu_shift = 1'b1; a_d = alu_res; p_d = alu_p;
                  end
                  8'h8a: begin a_d = x_q; p_d[7] = x_q[7]; p_d[1] = x_q == 8'd0; end
                  8'haa: begin x_d = a_q; p_d[7] = a_q[7]; p_d[1] = a_q == 8'd0; end
                  8'hca: begin x_d = x_q - 8'd1; p_d[7] = x_d[7]; p_d[1] = x_d == 8'd0; end
                  8'h9a: s_d = x_q;
                  8'hba: begin x_d = s_q; p_d[7] = s_q[7]; p_d[1] = s_q == 8'd0; end
                  8'h88: begin y_d = y_q - 8'd1; p_d[7] = y_d[7]; p_d[1] = y_d == 8'd0; end
                  8'ha8: begin y_d = a_q; p_d[7] = a_q[7]; p_d[1] = a_q == 8'd0; end
                  8'hc8: begin y_d = y_q + 8'd1; p_d[7] = y_d[7]; p_d[1] = y_d == 8'd0; end
                  8'he8: begin x_d = x_q + 8'd1; p_d[7] = x_d[7]; p_d[1] = x_d == 8'd0; end
                  8'h98: begin a_d = y_q; p_d[7] = y_q[7]; p_d[1] = y_q == 8'd0; end
                  8'h18: p_d[0] = 1'b0;
                  8'h38: p_d[0] = 1'b1;
                  8'h58: p_d[2] = 1'b0;
                  8'h78: p_d[2] = 1'b1;
                  8'hb8: p_d[6] = 1'b0;
                  8'hd8: p_d[3] = 1'b0;
                  8'hf8: p_d[3] = 1'b1;
                  default: ;
                endcase
                do_bound = 1'b1;
              end
              ebc_pkg::M_IMM, ebc_pkg::M_REL: begin
                ba = pc_d; pc_d = pc_d + 16'd1; seq_d = ebc_pkg::SQ_EXEC;
              end
              ebc_pkg::M_ZP, ebc_pkg::M_ZPX, ebc_pkg::M_ZPY: begin
                ba = pc_d; pc_d = pc_d + 16'd1; seq_d = ebc_pkg::SQ_ZP;
              end
              ebc_pkg::M_ABS, ebc_pkg::M_ABSX, ebc_pkg::M_ABSY: begin
                ba = pc_d; pc_d = pc_d + 16'd1; seq_d = ebc_pkg::SQ_ABS1;
              end
              ebc_pkg::M_INDX, ebc_pkg::M_INDY: begin
                ba = pc_d; pc_d = pc_d + 16'd1; seq_d = ebc_pkg::SQ_PTR;
              end
              default: begin halt_d = 1'b1; ba = pc_d; end
            endcase
          end
        end
        ebc_pkg::SQ_ZP: begin
          ea = {8'd0, d_i + idx_cur}; do_eff = 1'b1;
        end
        ebc_pkg::SQ_ABS1: begin
          dl_d = d_i;
          if (op_q == ebc_pkg::OP_JSR) begin
            bw = 1'b1; ba = {8'h01, s_q}; bd = pc_q[15:8]; s_d = s_q - 8'd1;
            seq_d = ebc_pkg::SQ_INT1;
          end else begin
            ba = pc_q; pc_d = pc_q + 16'd1; seq_d = ebc_pkg::SQ_ABS2;
          end
        end
        ebc_pkg::SQ_ABS2: begin
          if (op_q == ebc_pkg::OP_JSR) begin
            pc_d = absa; do_bound = 1'b1;
          end else if (op_q == ebc_pkg::OP_JMPI) begin
            al_d = absa; ba = absa; seq_d = ebc_pkg::SQ_PLO;
          end else begin
            ea = absa; do_eff = 1'b1;
          end
        end
        ebc_pkg::SQ_PTR: begin
          al_d = {8'd0, d_i + ((mode_cur == ebc_pkg::M_INDX) ? x_q : 8'd0)};
          ba = al_d; seq_d = ebc_pkg::SQ_PLO;
        end
        ebc_pkg::SQ_PLO: begin
          dl_d = d_i; ba = {al_q[15:8], al_q[7:0] + 8'd1}; seq_d = ebc_pkg::SQ_PHI;
        end
        ebc_pkg::SQ_PHI: begin
          if (op_q == ebc_pkg::OP_JMPI) begin
            pc_d = ptra; do_bound = 1'b1;
          end else begin
            ea = ptra + ((mode_cur == ebc_pkg::M_INDY) ? {8'd0, y_q} : 16'd0);
            do_eff = 1'b1;
          end
        end
        ebc_pkg::SQ_EXEC: begin
          if (op_q == ebc_pkg::OP_PLA) begin
            a_d = d_i; p_d[7] = d_i[7]; p_d[1] = d_i == 8'd0; do_bound = 1'b1;
          end else if (op_q == ebc_pkg::OP_PLP) begin
            p_d = d_i | ebc_pkg::FL_U | ebc_pkg::FL_B; do_bound = 1'b1;
          end else if (op_q == ebc_pkg::OP_RTI) begin
            p_d = d_i | ebc_pkg::FL_U | ebc_pkg::FL_B;
            s_d = s_q + 8'd1; ba = {8'h01, s_d}; seq_d = ebc_pkg::SQ_VEC1;
          end else if (mode_cur == ebc_pkg::M_REL) begin
            if (br_set == aaa[0]) pc_d = pc_q + {{8{d_i[7]}}, d_i};
            do_bound = 1'b1;
          end else if (op_q[1:0] == 2'd2 && aaa != 3'd4 && aaa != 3'd5) begin
            alu_shift = 1'b1; p_d = alu_p;
            bw = 1'b1; ba = al_q; bd = alu_res; seq_d = ebc_pkg::SQ_DONE;
          end else begin
            a_d = alu_a; x_d = alu_x; y_d = alu_y; p_d = alu_p; do_bound = 1'b1;
          end
        end
        ebc_pkg::SQ_DONE: do_bound = 1'b1;
        ebc_pkg::SQ_INT1: begin
          bw = 1'b1; ba = {8'h01, s_q}; bd = pc_q[7:0]; s_d = s_q - 8'd1;
          seq_d = (op_q == ebc_pkg::OP_JSR) ? ebc_pkg::SQ_JSRH : ebc_pkg::SQ_INT2;
        end
        ebc_pkg::SQ_INT2: begin
          bw = 1'b1; ba = {8'h01, s_q}; bd = dl_q; s_d = s_q - 8'd1;
          p_d = p_q | ebc_pkg::FL_I; seq_d = ebc_pkg::SQ_INT3;
        end
        ebc_pkg::SQ_INT3: begin
          ba = al_q; seq_d = ebc_pkg::SQ_VEC1;
        end
        default: begin
          ba = pc_q; seq_d = ebc_pkg::SQ_ABS2;
        end
      endcase

      if (do_eff) begin
        al_d = ea;
        if (aaa == 3'd4) begin
          bw = 1'b1; ba = ea;
          bd = (op_q[1:0] == 2'd1) ? a_q : ((op_q[1:0] == 2'd2) ? x_q : y_q);
          seq_d = ebc_pkg::SQ_DONE;
        end else if (op_q == ebc_pkg::OP_JMP) begin
          pc_d = ea; do_bound = 1'b1;
        end else begin
          ba = ea; seq_d = ebc_pkg::SQ_EXEC;
        end
      end

      // instruction boundary: NMI, then IRQ, else opcode fetch
      if (do_bound) begin
        pcur = (p_d | ebc_pkg::FL_U) & 8'hef;
        if (nmi_d || (irq_i && !p_d[2])) begin
          al_d = nmi_d ? ebc_pkg::VEC_NMI : ebc_pkg::VEC_IRQ;
          nmi_d = 1'b0; op_d = 8'd0; dl_d = pcur;
          bw = 1'b1; ba = {8'h01, s_d}; bd = pc_d[15:8]; s_d = s_d - 8'd1;
          seq_d = ebc_pkg::SQ_INT1;
        end else begin
          ba = pc_d; bf = 1'b1; seq_d = ebc_pkg::SQ_OP;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= ebc_pkg::SQ_RST0;
      a_q <= 8'd0; x_q <= 8'd0; y_q <= 8'd0; s_q <= 8'hff; p_q <= 8'h34;
      pc_q <= 16'd0; al_q <= 16'd0; op_q <= 8'd0; dl_q <= 8'd0;
      nmi_q <= 1'b0; halt_q <= 1'b0;
    end else if (step_i) begin
      seq_q <= seq_d;
      a_q <= a_d; x_q <= x_d; y_q <= y_d; s_q <= s_d; p_q <= p_d;
      pc_q <= pc_d; al_q <= al_d; op_q <= op_d; dl_q <= dl_d;
      nmi_q <= nmi_d; halt_q <= halt_d;
    end
  end

  always_comb begin
    res_o.bus_address = ba;
    res_o.bus_write = bw;
    res_o.write_data = bw ? bd : 8'd0;
    res_o.opcode_fetch = bf & ~halt_d;
    res_o.halted = halt_d;
    res_o.acc_out = a_d;
    res_o.x_out = x_d;
    res_o.y_out = y_d;
    res_o.sp_out = s_d;
    res_o.status_out = p_d;
    res_o.pc_out = pc_d;
  end
endmodule
`default_nettype wire

### rtl/core/eight_bit_cpu_core_bus_stepped_core.sv
// Stepped 6502 core: each input transfer produces one result transfer, held in the output register.
// Throughput: one item per cycle; input is taken whenever the output register is
// empty or being drained in the same cycle.
// Reset (rst_ni low, asynchronous): registers take power-up values and the output
// register is emptied; the first input starts the reset vector fetch.
`timescale 1ns / 1ps
`default_nettype none
module eight_bit_cpu_core_bus_stepped_core (
  input wire logic clk_i,
  input wire logic rst_ni,
  ebc_in_if.sink   in_if,
  ebc_out_if.source out_if
);
  ebc_pkg::result_t res_d, res_q;
  logic             vld_q;
  logic             take;

  assign in_if.ready = ~vld_q | out_if.ready;
  assign take = in_if.valid & in_if.ready;

  ebc_seq u_seq (
    .clk_i(clk_i), .rst_ni(rst_ni), .step_i(take), .cmd_i(in_if.cmd),
    .d_i(in_if.read_data), .nmi_i(in_if.nmi_request), .irq_i(in_if.irq_level),
    .res_o(res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_if.ready) begin
      vld_q <= in_if.valid;
    end
  end

  // hold the result until its transfer
  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign out_if.valid = vld_q;
  assign out_if.bus_address = res_q.bus_address;
  assign out_if.bus_write = res_q.bus_write;
  assign out_if.write_data = res_q.write_data;
  assign out_if.opcode_fetch = res_q.opcode_fetch;
  assign out_if.halted = res_q.halted;
  assign out_if.acc_out = res_q.acc_out;
  assign out_if.x_out = res_q.x_out;
  assign out_if.y_out = res_q.y_out;
  assign out_if.sp_out = res_q.sp_out;
  assign out_if.status_out = res_q.status_out;
  assign out_if.pc_out = res_q.pc_out;
endmodule
`default_nettype wire
